>>> rtl/core/latency_histogram_top_defines.svh
// Assertion macros for the latency histogram checker.
// Included by the checker file; no other dependencies.
`ifndef LATENCY_HISTOGRAM_TOP_DEFINES_SVH
`define LATENCY_HISTOGRAM_TOP_DEFINES_SVH
// Assert an implication on the rising clock edge, idle in reset.
`define LH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("latency_histogram check failed");
// Assert a next-cycle implication on the rising clock edge.
`define LH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("latency_histogram check failed");
`endif

>>> rtl/core/lh_pkg.sv
// Package for the latency histogram: sizes, types, sequencer states.
// No dependencies.
`default_nettype none
package lh_pkg;
    localparam int NumBins  = 1024;
    localparam int BinAw    = $clog2(NumBins);
    localparam int ClsW     = 11;
    localparam int NsPerUs  = 1000;
    localparam logic [1:0] RegLowest  = 2'd0;
    localparam logic [1:0] RegHighest = 2'd1;
    localparam logic [1:0] RegClasses = 2'd2;

    // ceil(2^UsRecipShift / (NsPerUs / 8)); exact for per-step times below UsLimitNs
    localparam logic [31:0] UsRecip      = 32'd2199023256;
    localparam int          UsRecipShift = 38;
    localparam logic [47:0] UsLimitNs    = 48'(NsPerUs) << 24;

    typedef struct packed {
        logic        action;
        logic [47:0] elapsed_ns;
        logic [31:0] step_count;
        logic [9:0]  bin_to_read;
    } t_in;

    typedef struct packed {
        logic        skipped;
        logic        in_range;
        logic [9:0]  bin_index;
        logic [31:0] bin_count;
        logic [31:0] binned_total;
        logic [47:0] average_ns;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DIV_PER, ST_DIV_US, ST_DIV_WID, ST_DIV_IDX,
        ST_RD, ST_WR, ST_DIV_AVG, ST_OUT
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

>>> rtl/core/lh_if.sv
// Valid/ready channel interface carrying a payload of generic type.
// Depends on nothing.
`default_nettype none
interface lh_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lh_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module lh_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> rtl/core/lh_div.sv
// Shared restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on lh_pkg.
`default_nettype none
module lh_div
    import lh_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [64:0] w_try;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_try  = {r_rem, r_quo[63]} - {1'b0, r_den};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift one numerator bit in, subtract if it fits
            if (!w_try[64]) begin
                n_rem = w_try[63:0];
            end else begin
                n_rem = {r_rem[62:0], r_quo[63]};
            end
            n_quo = {r_quo[62:0], !w_try[64]};
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quo: r_quo};
endmodule
`default_nettype wire

>>> rtl/core/latency_histogram_top.sv
// Top level of the latency histogram: APB registers, sequencer, bin store.
// Depends on lh_pkg, lh_if, lh_ram and lh_div.
//
// A record transaction makes up to three passes through one shared 64-bit
// restoring divider (per-step time, bin width, bin index; each when needed),
// turns the per-step time into microseconds by a reciprocal multiply, does a
// read-modify-write of the bin RAM, then makes a fourth divider pass for the
// running average. A record that misses the bin range skips the index pass
// and the RAM update. A read transaction takes one RAM read and the average
// pass. One transaction is in flight at a time; the finished result sits in
// an output register and the next input is taken while it waits. After reset
// a clearing pass writes zero into all 1024 bins, during which no input is
// accepted; APB writes are taken at all times and complete with pready always
// high.
`default_nettype none
module latency_histogram_top
    import lh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lh_if.sink               i_in,
    lh_if.source             o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    // configuration registers
    logic [23:0]     r_lowest, r_highest;
    logic [ClsW-1:0] r_classes;
    logic [1:0]      w_reg;
    assign w_reg  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= '0;
            r_highest <= 24'd1024;
            r_classes <= ClsW'(NumBins);
        end else if (psel && penable && pwrite) begin
            if (paddr[1:0] == 2'b00 && w_reg == RegLowest)  r_lowest  <= pwdata[23:0];
            if (paddr[1:0] == 2'b00 && w_reg == RegHighest) r_highest <= pwdata[23:0];
            if (paddr[1:0] == 2'b00 && w_reg == RegClasses) r_classes <= pwdata[ClsW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (w_reg)
                RegLowest:  prdata = {8'd0, r_lowest};
                RegHighest: prdata = {8'd0, r_highest};
                RegClasses: prdata = {21'd0, r_classes};
                default:    prdata = '0;
            endcase
        end
    end

    // effective class count, clamped to 1..NumBins
    logic [ClsW-1:0] w_cls;
    always_comb begin
        priority if (r_classes == '0) begin
            w_cls = ClsW'(1);
        end else if (r_classes > ClsW'(NumBins)) begin
            w_cls = ClsW'(NumBins);
        end else begin
            w_cls = r_classes;
        end
    end

    // sequencer state
    t_state      r_state, n_state;
    t_in         r_in;
    logic        r_first;
    logic [BinAw:0] r_clr;
    logic [47:0] r_per;
    logic [23:0] r_v;
    logic [23:0] r_width;
    logic [9:0]  r_idx;
    logic        r_hit;
    logic [31:0] r_binned, r_recorded;
    logic [63:0] r_sum;
    logic        r_outv;
    t_out        r_out;
    t_out        r_res;
    logic        r_started;

    t_div_req    w_req;
    t_div_rsp    w_rsp;
    lh_div u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));

    logic             w_we;
    logic [BinAw-1:0] w_addr;
    logic [31:0]      w_wdata, w_rdata;
    lh_ram #(.Width(32), .Depth(NumBins)) u_bins (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    logic w_acc;
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = r_outv;
    assign o_out.data  = r_out;

    // microseconds: drop the factor 8 of NsPerUs, multiply by the reciprocal
    // of the remaining 125; only per-step times below UsLimitNs need it
    logic [30:0] w_per8;
    logic [62:0] w_prod;
    assign w_per8 = r_per[33:3];
    assign w_prod = {32'd0, w_per8} * {31'd0, UsRecip};

    logic [23:0] w_diff;
    assign w_diff = (r_highest >= r_lowest) ? r_highest - r_lowest : 24'd0;
    logic [24:0] w_last;
    assign w_last = {1'b0, r_highest} + {1'b0, r_width} - 25'd1;
    logic w_vin;
    assign w_vin = ({1'b0, r_v} <= w_last) && (r_v >= r_lowest);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (r_clr[BinAw]) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in.data.action) n_state = ST_RD;
                    else if (r_first) n_state = ST_DIV_AVG;
                    else n_state = ST_DIV_PER;
                end
            end
            ST_DIV_PER: if (w_rsp.done) n_state = ST_DIV_US;
            ST_DIV_US:  n_state = ST_DIV_WID;
            ST_DIV_WID: if (w_rsp.done) n_state = ST_DIV_IDX;
            ST_DIV_IDX: begin
                if (!r_started && !w_vin) n_state = ST_DIV_AVG;
                else if (w_rsp.done) n_state = ST_RD;
            end
            // only a record that lands in a bin updates the store
            ST_RD:      n_state = (r_hit && !r_in.action) ? ST_WR : ST_DIV_AVG;
            ST_WR:      n_state = ST_DIV_AVG;
            ST_DIV_AVG: if (r_recorded == '0 || w_rsp.done) n_state = ST_OUT;
            ST_OUT:     if (!r_outv || o_out.ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // divider requests and RAM control
    logic [63:0] w_avg;
    always_comb begin
        w_req   = '{start: 1'b0, num: '0, den: 64'd1};
        w_we    = 1'b0;
        w_addr  = r_idx;
        w_wdata = '0;
        w_avg   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we   = !r_clr[BinAw];
                w_addr = r_clr[BinAw-1:0];
            end
            ST_DIV_PER: w_req = '{start: !r_started, num: {16'd0, r_in.elapsed_ns},
                                  den: {32'd0, (r_in.step_count == '0) ? 32'd1
                                                                       : r_in.step_count}};
            ST_DIV_WID: w_req = '{start: !r_started, num: {40'd0, w_diff},
                                  den: {53'd0, w_cls}};
            ST_DIV_IDX: w_req = '{start: !r_started && w_vin,
                                  num: {40'd0, r_v - r_lowest}, den: {40'd0, r_width}};
            ST_RD:      w_addr = r_idx;
            ST_WR: begin
                w_we    = 1'b1;
                w_wdata = (w_rdata == '1) ? w_rdata : w_rdata + 32'd1;
            end
            ST_DIV_AVG: w_req = '{start: !r_started && r_recorded != '0, num: r_sum,
                                  den: {32'd0, r_recorded}};
            default: ;
        endcase
        w_avg = (w_rsp.quo > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : w_rsp.quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_first    <= 1'b1;
            r_binned   <= '0;
            r_recorded <= '0;
            r_sum      <= '0;
            r_outv     <= 1'b0;
            r_started  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_started <= 1'b0;
            else if (w_req.start) r_started <= 1'b1;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_OUT && (!r_outv || o_out.ready)) r_outv <= 1'b1;
            else if (o_out.ready) r_outv <= 1'b0;
            if (w_acc && !i_in.data.action && r_first) r_first <= 1'b0;
            if (r_state == ST_DIV_PER && w_rsp.done) begin
                r_sum <= (r_sum > ~{16'd0, w_rsp.quo[47:0]}) ? '1
                                                             : r_sum + {16'd0, w_rsp.quo[47:0]};
                if (r_recorded != '1) r_recorded <= r_recorded + 32'd1;
            end
            if (r_state == ST_WR && r_binned != '1) r_binned <= r_binned + 32'd1;
        end
        // payload
        if (w_acc) begin
            r_in  <= i_in.data;
            r_hit <= i_in.data.action && ({1'b0, i_in.data.bin_to_read} < w_cls);
            r_idx <= i_in.data.bin_to_read;
            r_res <= '{skipped: !i_in.data.action && r_first, in_range: 1'b0,
                       bin_index: i_in.data.action ? i_in.data.bin_to_read : 10'd0,
                       bin_count: '0, binned_total: '0, average_ns: '0};
        end
        if (r_state == ST_DIV_PER && w_rsp.done) r_per <= w_rsp.quo[47:0];
        // saturate above 24 bits; such a value is never counted in a bin
        if (r_state == ST_DIV_US) begin
            r_v   <= (r_per >= UsLimitNs) ? 24'hFF_FFFF
                                          : w_prod[UsRecipShift+23:UsRecipShift];
            r_hit <= (r_per < UsLimitNs);
        end
        if (r_state == ST_DIV_WID && w_rsp.done) begin
            r_width <= (w_rsp.quo[23:0] == '0) ? 24'd1 : w_rsp.quo[23:0];
        end
        if (r_state == ST_DIV_IDX && !r_started && !w_vin) r_hit <= 1'b0;
        if (r_state == ST_DIV_IDX && w_rsp.done) begin
            r_hit <= r_hit && (w_rsp.quo < {53'd0, w_cls});
            r_idx <= w_rsp.quo[9:0];
        end
        if (r_state == ST_RD) begin
            if (r_hit) begin
                r_res.in_range  <= 1'b1;
                r_res.bin_index <= r_idx;
            end
        end
        if (r_state == ST_WR) begin
            r_res.bin_count <= w_wdata;
        end
        if (r_state == ST_DIV_AVG && r_res.in_range && r_in.action) begin
            r_res.bin_count <= w_rdata;
        end
        if (r_state == ST_OUT && (!r_outv || o_out.ready)) begin
            r_out <= '{skipped: r_res.skipped, in_range: r_res.in_range,
                       bin_index: r_res.bin_index, bin_count: r_res.bin_count,
                       binned_total: r_binned,
                       average_ns: (r_recorded == '0) ? 48'd0 : r_res.average_ns};
        end
        if (r_state == ST_DIV_AVG && w_rsp.done) r_res.average_ns <= w_avg[47:0];
    end
endmodule
`default_nettype wire

>>> rtl/core/lh_checker.sv
// Port-level checker for latency_histogram_top, bound to the top level.
// Depends on latency_histogram_top_defines.svh and lh_pkg.
`default_nettype none
`include "latency_histogram_top_defines.svh"
module lh_checker
    import lh_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire t_out out_data
);
    `LH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `LH_ASSERT_IMPL(a_skip_clean, i_clk, i_rst_n, out_valid && out_data.skipped, !out_data.in_range && out_data.bin_count == '0)
    `LH_ASSERT_IMPL(a_hit_count, i_clk, i_rst_n, out_valid && !out_data.in_range, out_data.bin_count == '0)
    `LH_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
endmodule

bind latency_histogram_top lh_checker u_chk (
    .i_clk, .i_rst_n,
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data)
);
`default_nettype wire
